// ===== design/linked_queue_manager_unit_defines.svh =====
// assertion macros shared by the rtl files
// each one samples on clk and is switched off while rst_n is low
`ifndef LINKED_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define LINKED_QUEUE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define LQM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LQM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lqm_pkg.sv =====
`default_nettype none
package lqm_pkg;

    localparam int POOL_SIZE  = 256;
    localparam int NUM_QUEUES = 8;
    localparam int DATA_BITS  = 16;

    // field widths of the channels
    localparam int CMD_W    = 2;
    localparam int QSEL_W   = 3;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // pointer into the pool, one code above the last entry is null
    localparam int ADDR_W = $clog2(POOL_SIZE);
    localparam int PTR_W  = $clog2(POOL_SIZE + 1);
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int QIDX_W = $clog2(NUM_QUEUES);

    localparam logic [PTR_W-1:0] PTR_NIL  = PTR_W'(POOL_SIZE);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_SIZE - 1);

    localparam logic [CMD_W-1:0] CMD_PUT   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_GET   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(2);

    localparam logic [STATUS_W-1:0] STAT_OK          = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STAT_POOL_EMPTY  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STAT_QUEUE_EMPTY = STATUS_W'(2);

    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [DATA_BITS-1:0] word_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } lqm_ctrl_t;

endpackage
`default_nettype wire

// ===== design/lqm_if.sv =====
`default_nettype none
interface lqm_req_if;
    import lqm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [QSEL_W-1:0] queue_sel;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output cmd, output queue_sel, output data_in, input ready);
    modport sink   (input valid, input cmd, input queue_sel, input data_in, output ready);
endinterface

interface lqm_rsp_if;
    import lqm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [COUNT_W-1:0]  count_out;

    modport source (output valid, output status, output data_out, output count_out, input ready);
    modport sink   (input valid, input status, input data_out, input count_out, output ready);
endinterface
`default_nettype wire

// ===== design/lqm_ctrl.sv =====
`default_nettype none
`include "linked_queue_manager_unit_defines.svh"
module lqm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output lqm_pkg::lqm_ctrl_t     ctrl
);
    import lqm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    // the result register is free if empty or being drained this cycle
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next  = state_reg;
        ctrl.accept = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `LQM_ASSERT_NEXT(a_accept_enters_exec, req_valid && req_ready, state_reg == ST_EXEC && !req_ready, "accepted request did not start execution")
    `LQM_ASSERT_NEXT(a_commit_shows_result, ctrl.commit, rsp_valid_reg && state_reg == ST_IDLE, "committed request gave no result")

endmodule
`default_nettype wire

// ===== design/lqm_dpath.sv =====
`default_nettype none
`include "linked_queue_manager_unit_defines.svh"
module lqm_dpath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lqm_pkg::lqm_ctrl_t              ctrl,
    input  wire logic [lqm_pkg::CMD_W-1:0]       cmd,
    input  wire logic [lqm_pkg::QSEL_W-1:0]      queue_sel,
    input  wire logic [lqm_pkg::DATA_W-1:0]      data_in,
    output logic      [lqm_pkg::STATUS_W-1:0]    status,
    output logic      [lqm_pkg::DATA_W-1:0]      data_out,
    output logic      [lqm_pkg::COUNT_W-1:0]     count_out
);
    import lqm_pkg::*;

    // pools
    ptr_t  link_mem [POOL_SIZE];
    word_t word_mem [POOL_SIZE];

    // per-queue state
    ptr_t head_reg  [NUM_QUEUES];
    ptr_t tail_reg  [NUM_QUEUES];
    cnt_t count_reg [NUM_QUEUES];

    ptr_t free_head_reg;
    ptr_t free_head_next;
    // entries below the watermark were never taken and still hold the reset chain
    ptr_t wmark_reg;
    ptr_t wmark_next;

    // latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [QSEL_W-1:0] qsel_reg;
    word_t             word_in_reg;

    ptr_t  rd_ptr;
    ptr_t  rd_ptr_reg;
    ptr_t  link_rd_reg;
    word_t word_rd_reg;
    ptr_t  link_val;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_new;
    logic [DATA_W-1:0]   data_out_reg;
    logic [DATA_W-1:0]   data_out_new;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [COUNT_W-1:0]  count_out_new;

    logic [QIDX_W-1:0] qidx_in;
    logic [QIDX_W-1:0] qidx;
    logic              q_ok;
    ptr_t              q_head;
    ptr_t              q_tail;
    cnt_t              q_cnt;
    logic              tail_ok;
    logic              head_ok;
    logic              pool_ok;

    logic q_we;
    ptr_t head_new;
    ptr_t tail_new;
    cnt_t count_new;

    logic              link_we;
    logic [ADDR_W-1:0] link_wa;
    ptr_t              link_wd;
    logic              word_we;

    assign qidx_in = queue_sel[QIDX_W-1:0];
    assign rd_ptr  = (cmd == CMD_PUT) ? free_head_reg : head_reg[qidx_in];

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg     <= cmd;
            qsel_reg    <= queue_sel;
            word_in_reg <= data_in[DATA_BITS-1:0];
            rd_ptr_reg  <= rd_ptr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            link_rd_reg <= link_mem[rd_ptr[ADDR_W-1:0]];
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            word_rd_reg <= word_mem[head_reg[qidx_in][ADDR_W-1:0]];
        end
        if (word_we)
        begin
            word_mem[free_head_reg[ADDR_W-1:0]] <= word_in_reg;
        end
    end

    // untouched entries chain downwards, entry zero ends the list
    always_comb
    begin
        if (rd_ptr_reg >= wmark_reg)
        begin
            link_val = link_rd_reg;
        end
        else if (rd_ptr_reg == '0)
        begin
            link_val = PTR_NIL;
        end
        else
        begin
            link_val = rd_ptr_reg - PTR_W'(1);
        end
    end

    assign qidx    = qsel_reg[QIDX_W-1:0];
    assign q_ok    = 32'(qsel_reg) < NUM_QUEUES;
    assign q_head  = head_reg[qidx];
    assign q_tail  = tail_reg[qidx];
    assign q_cnt   = count_reg[qidx];
    assign tail_ok = 32'(q_tail) < POOL_SIZE;
    assign head_ok = 32'(q_head) < POOL_SIZE;
    assign pool_ok = 32'(free_head_reg) < POOL_SIZE;

    always_comb
    begin
        status_new     = STAT_OK;
        data_out_new   = '0;
        count_out_new  = '0;
        free_head_next = free_head_reg;
        wmark_next     = wmark_reg;
        q_we           = 1'b0;
        head_new       = q_head;
        tail_new       = q_tail;
        count_new      = q_cnt;
        link_we        = 1'b0;
        link_wa        = q_tail[ADDR_W-1:0];
        link_wd        = free_head_reg;
        word_we        = 1'b0;
        if (q_ok)
        begin
            unique case (cmd_reg)
                CMD_PUT:
                begin
                    if (!pool_ok)
                    begin
                        status_new = STAT_POOL_EMPTY;
                    end
                    else
                    begin
                        free_head_next = link_val;
                        if (free_head_reg < wmark_reg)
                        begin
                            wmark_next = free_head_reg;
                        end
                        word_we = 1'b1;
                        q_we    = 1'b1;
                        if (q_cnt == '0 || !tail_ok)
                        begin
                            head_new = free_head_reg;
                        end
                        else
                        begin
                            link_we = 1'b1;
                            link_wa = q_tail[ADDR_W-1:0];
                            link_wd = free_head_reg;
                        end
                        tail_new      = free_head_reg;
                        count_new     = q_cnt + CNT_W'(1);
                        count_out_new = COUNT_W'(count_new);
                    end
                end
                CMD_GET:
                begin
                    if (q_cnt == '0 || !head_ok)
                    begin
                        status_new = STAT_QUEUE_EMPTY;
                    end
                    else
                    begin
                        q_we      = 1'b1;
                        count_new = q_cnt - CNT_W'(1);
                        if (count_new == '0)
                        begin
                            head_new = PTR_NIL;
                            tail_new = PTR_NIL;
                        end
                        else
                        begin
                            head_new = link_val;
                        end
                        link_we        = 1'b1;
                        link_wa        = q_head[ADDR_W-1:0];
                        link_wd        = free_head_reg;
                        free_head_next = q_head;
                        data_out_new   = DATA_W'(word_rd_reg);
                    end
                end
                CMD_CLEAR:
                begin
                    // whole queue goes in front of the free list
                    if (q_cnt != '0 && tail_ok)
                    begin
                        link_we        = 1'b1;
                        link_wa        = q_tail[ADDR_W-1:0];
                        link_wd        = free_head_reg;
                        free_head_next = q_head;
                        q_we           = 1'b1;
                        count_new      = '0;
                        head_new       = PTR_NIL;
                        tail_new       = PTR_NIL;
                    end
                end
                default:
                begin
                    status_new = STAT_OK;
                end
            endcase
        end
        if (!ctrl.commit)
        begin
            link_we = 1'b0;
            word_we = 1'b0;
            q_we    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= PTR_LAST;
            wmark_reg     <= PTR_NIL;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= PTR_NIL;
                tail_reg[i]  <= PTR_NIL;
                count_reg[i] <= '0;
            end
        end
        else if (ctrl.commit)
        begin
            free_head_reg <= free_head_next;
            wmark_reg     <= wmark_next;
            if (q_we)
            begin
                head_reg[qidx]  <= head_new;
                tail_reg[qidx]  <= tail_new;
                count_reg[qidx] <= count_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg    <= status_new;
            data_out_reg  <= data_out_new;
            count_out_reg <= count_out_new;
        end
    end

    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign count_out = count_out_reg;

    `LQM_ASSERT_IMPLY(a_free_head_range, 1'b1, free_head_reg <= PTR_NIL && wmark_reg <= PTR_NIL, "free-list pointer out of range")
    `LQM_ASSERT_IMPLY(a_untouched_order, free_head_reg < wmark_reg, free_head_reg == wmark_reg - PTR_W'(1), "free list reached an untouched entry out of order")

endmodule
`default_nettype wire

// ===== design/linked_queue_manager_unit.sv =====
// linked queue manager: eight fifo queues share a pool of 256 buffer entries
// requests arrive on req (cmd, queue_sel, data_in) with a valid/ready handshake
// cmd put appends data_in to the queue, get removes its head word, clear
// returns the whole queue to the free list; one response per request on rsp
// response: status 0 ok, 1 pool exhausted on put, 2 queue empty on get;
// data_out holds the word of a successful get, count_out the queue length
// after a successful put, all other fields zero
// the response is registered in the step that updates the lists
// requests do not overlap: the first step of each reads the link and word
// memories, the second updates the lists through the single link write port
// a new request is taken while the previous response still waits on rsp; if
// rsp stays stalled the second request holds in its update cycle until the
// waiting response is taken, and req.ready stays low meanwhile
// reset: every queue empty and the whole pool on the free list at once; no
// clearing pass, entries never used are tracked by a watermark register
`default_nettype none
module linked_queue_manager_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lqm_req_if.sink    req,
    lqm_rsp_if.source  rsp
);
    import lqm_pkg::*;

    lqm_ctrl_t ctrl;

    lqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    lqm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (req.cmd),
        .queue_sel (req.queue_sel),
        .data_in   (req.data_in),
        .status    (rsp.status),
        .data_out  (rsp.data_out),
        .count_out (rsp.count_out)
    );

endmodule
`default_nettype wire

// ===== sim/linked_queue_manager_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module linked_queue_manager_unit_tb;
    import lqm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
        logic [COUNT_W-1:0]  count_out;
    } response_t;

    logic clk = 1'b0;
    logic rst_n;

    lqm_req_if req ();
    lqm_rsp_if rsp ();

    linked_queue_manager_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // shadow of the pool: next pointers, words, free list and queue descriptors
    ptr_t  pool_next [POOL_SIZE];
    word_t pool_word [POOL_SIZE];
    ptr_t  free_top;
    ptr_t  q_first [NUM_QUEUES];
    ptr_t  q_last  [NUM_QUEUES];
    cnt_t  q_len   [NUM_QUEUES];

    response_t responses_due [$];

    int err_count = 0;
    int requests_sent;
    int puts_ok, puts_refused, gets_ok, gets_empty, clears, unused_cmds;
    int longest_queue;

    // sender and receiver idling controls
    int gap_max;
    int burst_left;
    int stall_pct;
    int stall_max;
    int idle_cycles = 0;

    function automatic response_t queue_op_outcome(input logic [CMD_W-1:0] op,
                                                   input logic [QSEL_W-1:0] qs,
                                                   input logic [DATA_W-1:0] word);
        response_t         r;
        ptr_t              p;
        logic [QIDX_W-1:0] q;
        r = '0;
        q = qs[QIDX_W-1:0];
        if (int'(qs) < NUM_QUEUES) begin
            if (op == CMD_PUT) begin
                p = free_top;
                if (p >= PTR_NIL) begin
                    r.status = STAT_POOL_EMPTY;
                    puts_refused++;
                end
                else begin
                    free_top = pool_next[p[ADDR_W-1:0]];
                    pool_next[p[ADDR_W-1:0]] = PTR_NIL;
                    pool_word[p[ADDR_W-1:0]] = word_t'(word);
                    if (q_len[q] == 0)
                        q_first[q] = p;
                    else
                        pool_next[q_last[q][ADDR_W-1:0]] = p;
                    q_last[q] = p;
                    q_len[q]++;
                    r.count_out = COUNT_W'(q_len[q]);
                    puts_ok++;
                    if (int'(q_len[q]) > longest_queue)
                        longest_queue = int'(q_len[q]);
                end
            end
            else if (op == CMD_GET) begin
                p = q_first[q];
                if (q_len[q] == 0) begin
                    r.status = STAT_QUEUE_EMPTY;
                    gets_empty++;
                end
                else begin
                    q_len[q]--;
                    if (q_len[q] == 0) begin
                        q_first[q] = PTR_NIL;
                        q_last[q]  = PTR_NIL;
                    end
                    else begin
                        q_first[q] = pool_next[p[ADDR_W-1:0]];
                    end
                    pool_next[p[ADDR_W-1:0]] = free_top;
                    free_top = p;
                    r.data_out = DATA_W'(pool_word[p[ADDR_W-1:0]]);
                    gets_ok++;
                end
            end
            else if (op == CMD_CLEAR) begin
                // whole chain goes onto the front of the free list
                if (q_len[q] != 0) begin
                    pool_next[q_last[q][ADDR_W-1:0]] = free_top;
                    free_top = q_first[q];
                    q_len[q]   = '0;
                    q_first[q] = PTR_NIL;
                    q_last[q]  = PTR_NIL;
                end
                clears++;
            end
            else begin
                unused_cmds++;
            end
        end
        return r;
    endfunction

    task automatic send_req(input logic [CMD_W-1:0] op, input logic [QSEL_W-1:0] qs,
                            input logic [DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                @(negedge clk);
                req.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        req.valid     <= 1'b1;
        req.cmd       <= op;
        req.queue_sel <= qs;
        req.data_in   <= word;
        do @(posedge clk); while (!req.ready);
        responses_due.push_back(queue_op_outcome(op, qs, word));
        requests_sent++;
    endtask

    task automatic wait_all_answered();
        @(negedge clk);
        req.valid <= 1'b0;
        burst_left = 0;
        while (responses_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return DATA_W'($urandom);
    endfunction

    // favours the low queues so that some of them grow long
    function automatic logic [QSEL_W-1:0] pick_queue();
        if ($urandom_range(0, 1))
            return QSEL_W'($urandom_range(0, 1));
        return QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
    endfunction

    task automatic test_directed();
        gap_max   = 2;
        stall_pct = 20;
        stall_max = 3;
        send_req(CMD_GET,    3'd0, 16'h0000);   // get from an empty queue
        send_req(CMD_CLEAR,  3'd3, 16'hffff);   // clear of an empty queue
        send_req(CMD_PUT,    3'd0, 16'h0000);
        send_req(CMD_PUT,    3'd0, 16'hffff);
        send_req(CMD_PUT,    3'd7, 16'ha5a5);
        send_req(CMD_PUT,    3'd7, 16'h5a5a);
        send_req(CMD_GET,    3'd0, 16'hffff);
        send_req(CMD_GET,    3'd0, 16'h0000);
        send_req(CMD_GET,    3'd0, 16'h0000);
        send_req(CMD_UNUSED, 3'd5, 16'hffff);
        send_req(CMD_PUT,    3'd7, 16'h8001);
        send_req(CMD_CLEAR,  3'd7, 16'h0000);
        send_req(CMD_GET,    3'd7, 16'h0000);
        send_req(CMD_PUT,    3'd7, 16'h1234);
        send_req(CMD_GET,    3'd7, 16'h0000);
        send_req(CMD_UNUSED, 3'd0, 16'h0000);
        send_req(CMD_PUT,    3'd2, 16'h8000);
        send_req(CMD_PUT,    3'd2, 16'h0001);
        send_req(CMD_PUT,    3'd5, 16'h7fff);
        send_req(CMD_CLEAR,  3'd2, 16'h0000);
        send_req(CMD_GET,    3'd5, 16'h0000);
        send_req(CMD_GET,    3'd2, 16'h0000);
    endtask

    task automatic test_pool_exhaustion();
        int target;
        int q;
        gap_max   = 3;
        stall_pct = 15;
        stall_max = 5;
        target = puts_refused + 6;
        while (puts_refused < target)
            send_req(CMD_PUT, QSEL_W'($urandom_range(0, NUM_QUEUES - 1)), pick_word());
        // hold off until the pool is quiet, then hand everything back
        wait_all_answered();
        for (q = 0; q < NUM_QUEUES / 2; q++)
            send_req(CMD_CLEAR, QSEL_W'(q), pick_word());
        for (q = NUM_QUEUES / 2; q < NUM_QUEUES; q++) begin
            while (q_len[QIDX_W'(q)] != 0)
                send_req(CMD_GET, QSEL_W'(q), pick_word());
            send_req(CMD_GET, QSEL_W'(q), pick_word());
        end
        send_req(CMD_PUT, 3'd0, pick_word());
        send_req(CMD_GET, 3'd0, pick_word());
    endtask

    task automatic test_random_mix(input int items, input int put_pct, input int get_pct,
                                   input int clear_pct);
        int i;
        int r;
        logic [CMD_W-1:0] op;
        for (i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < put_pct)
                op = CMD_PUT;
            else if (r < put_pct + get_pct)
                op = CMD_GET;
            else if (r < put_pct + get_pct + clear_pct)
                op = CMD_CLEAR;
            else
                op = CMD_UNUSED;
            send_req(op, pick_queue(), pick_word());
        end
    endtask

    // receiver: stalls of random length started at random
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n) begin
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct) begin
                rsp.ready <= 1'b0;
                stall_left = $urandom_range(0, stall_max);
            end
            else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (responses_due.size() == 0) begin
                $error("response with no request outstanding: status %0d data %h count %0d",
                       rsp.status, rsp.data_out, rsp.count_out);
                err_count++;
            end
            else begin
                want = responses_due.pop_front();
                if (rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    err_count++;
                end
                if (rsp.data_out !== want.data_out) begin
                    $error("data_out: expected %h, actual %h", want.data_out, rsp.data_out);
                    err_count++;
                end
                if (rsp.count_out !== want.count_out) begin
                    $error("count_out: expected %0d, actual %0d", want.count_out,
                           rsp.count_out);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.cmd       <= CMD_PUT;
        req.queue_sel <= '0;
        req.data_in   <= '0;
        requests_sent = 0;
        puts_ok       = 0;
        puts_refused  = 0;
        gets_ok       = 0;
        gets_empty    = 0;
        clears        = 0;
        unused_cmds   = 0;
        longest_queue = 0;
        gap_max       = 0;
        burst_left    = 0;
        stall_pct     = 0;
        stall_max     = 0;

        // after reset every entry is on the free list, entry i linked to i-1
        pool_next[0] = PTR_NIL;
        pool_word[0] = '0;
        for (i = 1; i < POOL_SIZE; i++) begin
            pool_next[ADDR_W'(i)] = ptr_t'(i - 1);
            pool_word[ADDR_W'(i)] = '0;
        end
        free_top = PTR_LAST;
        for (i = 0; i < NUM_QUEUES; i++) begin
            q_first[QIDX_W'(i)] = PTR_NIL;
            q_last[QIDX_W'(i)]  = PTR_NIL;
            q_len[QIDX_W'(i)]   = '0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_exhaustion();

        // back to back on both sides
        gap_max   = 0;
        stall_pct = 0;
        test_random_mix(150, 55, 35, 7);

        gap_max   = 4;
        stall_pct = 40;
        stall_max = 8;
        test_random_mix(150, 40, 50, 5);

        gap_max   = 2;
        stall_pct = 10;
        stall_max = 2;
        test_random_mix(150, 70, 25, 3);

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d puts stored, %0d refused on a full pool, longest queue %0d",
                 requests_sent, puts_ok, puts_refused, longest_queue);
        $display("%0d gets returned a word, %0d hit an empty queue, %0d clears, %0d unused",
                 gets_ok, gets_empty, clears, unused_cmds);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
